// ===== rtl/lzwe_pkg.sv =====
`timescale 1ns / 1ps
package lzwe_pkg;

	localparam int DICT_SIZE    = 4096;
	localparam int CODE_W       = 12;
	localparam int WID_W        = 4;
	localparam int SYM_W        = 8;
	localparam int CS_W         = 4;
	localparam int MAX_SYM_BITS = 8;
	localparam int KEY_W        = CODE_W + SYM_W;
	// Hash table has twice as many slots as codes, so it stays at most half full.
	localparam int SLOT_AW      = CODE_W + 1;
	localparam int NEXT_W       = CODE_W + 1;

	localparam logic [1:0] OP_DATA  = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef struct packed {
		logic              last;
		logic [WID_W-1:0]  width;
		logic [CODE_W-1:0] code;
	} res_t;

	// Up to two results written to the output queue in one cycle, r0 first.
	typedef struct packed {
		logic en0;
		logic en1;
		res_t r0;
		res_t r1;
	} push_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [CODE_W-1:0] code;
	} slot_t;

	// Symbol bits in use, limited to the widest symbol.
	function automatic logic [CS_W-1:0] eff_cs(input logic [CS_W-1:0] cs);
		return (cs > CS_W'(MAX_SYM_BITS)) ? CS_W'(MAX_SYM_BITS) : cs;
	endfunction

	// Number of literal codes; clear code equals it, end code is one above.
	function automatic logic [CODE_W-1:0] base_of(input logic [CS_W-1:0] cs);
		return CODE_W'(1) << eff_cs(cs);
	endfunction

	function automatic logic [NEXT_W-1:0] init_next(input logic [CS_W-1:0] cs);
		return NEXT_W'(base_of(cs)) + NEXT_W'(2);
	endfunction

	// ceil(log2(base + 2))
	function automatic logic [WID_W-1:0] init_width(input logic [CS_W-1:0] cs);
		logic [CS_W-1:0] e;
		e = eff_cs(cs);
		return (e <= CS_W'(1)) ? WID_W'(2) : WID_W'(e + CS_W'(1));
	endfunction

	// Fold the 20-bit key into a slot address.
	function automatic logic [SLOT_AW-1:0] hash_of(input logic [KEY_W-1:0] key);
		return {key[SYM_W-1:0], key[SLOT_AW-1:SYM_W]}
			^ SLOT_AW'(key[KEY_W-1:SLOT_AW]);
	endfunction

endpackage

// ===== rtl/lzwe_out_fifo.sv =====
`timescale 1ns / 1ps
module lzwe_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  lzwe_pkg::push_t push,
	input  logic            pop,
	output lzwe_pkg::res_t  head,
	output logic            not_empty,
	output logic            room
);
	import lzwe_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	res_t               buf_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [PTR_W:0]     cnt_q;
	logic [PTR_W:0]     n_push;
	logic [PTR_W-1:0]   wr_next;

	assign n_push    = (PTR_W+1)'(push.en0) + (PTR_W+1)'(push.en1);
	assign wr_next   = wr_q + PTR_W'(1);
	assign head      = buf_q[rd_q];
	assign not_empty = (cnt_q != '0);
	// Room for the largest burst one item can cause.
	assign room      = (cnt_q <= (PTR_W+1)'(1));

	// Storage
	always_ff @(posedge clk) begin
		if (push.en0) begin
			buf_q[wr_q] <= push.r0;
		end
		if (push.en1) begin
			buf_q[wr_next] <= push.r1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + PTR_W'(n_push);
			if (pop && not_empty) begin
				rd_q  <= rd_q + PTR_W'(1);
				cnt_q <= cnt_q + n_push - (PTR_W+1)'(1);
			end else begin
				cnt_q <= cnt_q + n_push;
			end
		end
	end

endmodule

// ===== rtl/lzw_stream_encoder.sv =====
`timescale 1ns / 1ps
// LZW encoder, variable code width. Throughput: one item per cycle while the encoder is
// idle and the output has room, except a data byte with a pending string, which takes
// a hash slot read, then a compare and insert, plus one more probe step per slot
// collision. Input stalls while two or more results wait at the output. Reset, a
// code_size write and every dictionary clear start a wipe of all 8192 hash slots; no
// item is processed meanwhile.
module lzw_stream_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,    // code_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // [7:0] data_byte
	input  logic [1:0]  s_tuser,      // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,      // [11:0] code, [15:12] code_width
	output logic        m_tlast
);
	import lzwe_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_PROBE = 2'd2;
	localparam int SLOTS = 1 << SLOT_AW;

	logic [1:0]         state_q;
	logic [SLOT_AW-1:0] clr_addr_q;
	logic [CS_W-1:0]    cs_q;
	logic [CODE_W-1:0]  prefix_q;
	logic               pending_q;
	logic [NEXT_W-1:0]  next_q;
	logic [WID_W-1:0]   width_q;
	logic               started_q;
	logic               ended_q;

	logic               in_full_q;
	logic [1:0]         in_op_q;
	logic [SYM_W-1:0]   in_byte_q;

	logic [KEY_W-1:0]   key_s1;
	logic [SYM_W-1:0]   byte_s1;
	logic [SLOT_AW-1:0] probe_addr_s1;
	slot_t              rd_slot_s1;

	slot_t              slot_mem [SLOTS];

	logic [CODE_W-1:0]  base;
	logic [SYM_W-1:0]   sym;
	logic [KEY_W-1:0]   key_now;
	logic               room;
	logic               take;
	logic               active;
	logic               hit;
	logic               miss;
	logic               dict_full;
	logic [WID_W-1:0]   width_new;
	push_t              push;
	logic               mem_we;
	logic [SLOT_AW-1:0] mem_wa;
	slot_t              mem_wd;
	logic               mem_re;
	logic [SLOT_AW-1:0] mem_ra;
	res_t               head;

	assign base     = base_of(cs_q);
	assign sym      = in_byte_q & SYM_W'(base - CODE_W'(1));
	assign key_now  = {prefix_q, sym};
	// Holding register refills in the cycle its item is taken.
	assign s_tready = !in_full_q || take;
	assign take     = (state_q == ST_IDLE) && in_full_q && room;
	assign active   = take && !ended_q && (in_op_q != OP_NONE);

	assign hit       = rd_slot_s1.valid && (rd_slot_s1.key == key_s1);
	assign miss      = !rd_slot_s1.valid;
	assign dict_full = (next_q == NEXT_W'(DICT_SIZE - 1));
	// Width grows when the next free code reaches a power of two.
	assign width_new = (next_q == (NEXT_W'(1) << width_q)) ? width_q + WID_W'(1) : width_q;

	// Result generation and memory access control
	always_comb begin
		push   = '0;
		mem_we = 1'b0;
		mem_wa = clr_addr_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = hash_of(key_now);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (active) begin
					case (in_op_q) inside
						OP_DATA: begin
							// Stream opens with a clear code; no string is pending then.
							if (!started_q) begin
								push.en0 = 1'b1;
								push.r0  = '{last: 1'b1, width: width_q, code: base};
							end
							if (pending_q) begin
								mem_re = 1'b1;
							end
						end
						OP_END, OP_CLEAR: begin
							if (pending_q) begin
								push.en0 = 1'b1;
								push.r0  = '{last: 1'b0, width: width_q, code: prefix_q};
								push.en1 = 1'b1;
								push.r1.last  = 1'b1;
								push.r1.width = width_q;
								push.r1.code  = (in_op_q == OP_END) ? base + CODE_W'(1) : base;
							end else begin
								push.en0 = 1'b1;
								push.r0.last  = 1'b1;
								push.r0.width = width_q;
								push.r0.code  = (in_op_q == OP_END) ? base + CODE_W'(1) : base;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_PROBE: begin
				if (miss) begin
					push.en0 = 1'b1;
					push.r0  = '{last: !dict_full, width: width_q, code: prefix_q};
					push.en1 = dict_full;
					push.r1  = '{last: 1'b1, width: width_new, code: base};
					mem_we   = 1'b1;
					mem_wa   = probe_addr_s1;
					mem_wd   = '{valid: 1'b1, key: key_s1, code: next_q[CODE_W-1:0]};
				end else if (!hit) begin
					// Collision: step to the following slot.
					mem_re = 1'b1;
					mem_ra = probe_addr_s1 + SLOT_AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Hash slot memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_slot_s1    <= slot_mem[mem_ra];
			probe_addr_s1 <= mem_ra;
		end
	end

	// Lookup key carried into the probe stage
	always_ff @(posedge clk) begin
		if (active && (in_op_q == OP_DATA) && pending_q) begin
			key_s1  <= key_now;
			byte_s1 <= sym;
		end
	end

	// Input holding register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_op_q   <= s_tuser;
			in_byte_q <= s_tdata;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			cs_q       <= CS_W'(MAX_SYM_BITS);
			prefix_q   <= '0;
			pending_q  <= 1'b0;
			next_q     <= init_next(CS_W'(MAX_SYM_BITS));
			width_q    <= init_width(CS_W'(MAX_SYM_BITS));
			started_q  <= 1'b0;
			ended_q    <= 1'b0;
			in_full_q  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				in_full_q <= 1'b1;
			end else if (take) begin
				in_full_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + SLOT_AW'(1);
					if (clr_addr_q == SLOT_AW'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (active) begin
						case (in_op_q)
							OP_DATA: begin
								started_q <= 1'b1;
								if (!pending_q) begin
									prefix_q  <= CODE_W'(sym);
									pending_q <= 1'b1;
								end else begin
									state_q <= ST_PROBE;
								end
							end
							OP_END: begin
								prefix_q  <= '0;
								pending_q <= 1'b0;
								ended_q   <= 1'b1;
							end
							OP_CLEAR: begin
								prefix_q   <= '0;
								pending_q  <= 1'b0;
								next_q     <= init_next(cs_q);
								width_q    <= init_width(cs_q);
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PROBE: begin
					if (hit) begin
						prefix_q <= rd_slot_s1.code;
						state_q  <= ST_IDLE;
					end else if (miss) begin
						prefix_q  <= CODE_W'(byte_s1);
						pending_q <= 1'b1;
						if (dict_full) begin
							next_q     <= init_next(cs_q);
							width_q    <= init_width(cs_q);
							clr_addr_q <= '0;
							state_q    <= ST_CLEAR;
						end else begin
							next_q  <= next_q + NEXT_W'(1);
							width_q <= width_new;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase

			// Register write restarts the stream with the new symbol size.
			if (cfg_we) begin
				cs_q       <= cfg_wdata;
				prefix_q   <= '0;
				pending_q  <= 1'b0;
				next_q     <= init_next(cfg_wdata);
				width_q    <= init_width(cfg_wdata);
				started_q  <= 1'b0;
				ended_q    <= 1'b0;
				clr_addr_q <= '0;
				state_q    <= ST_CLEAR;
			end
		end
	end

	lzwe_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.room      (room)
	);

	assign m_tdata = {head.width, head.code};
	assign m_tlast = head.last;

endmodule

// ===== rtl/lzwe_checker.sv =====
`timescale 1ns / 1ps
module lzwe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// Stalled transfer stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	// Stalled payload holds
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed while stalled");

	// Code width stays within the variable width range
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:12] >= 4'd2) && (m_tdata[15:12] <= 4'd12))
		else $error("code width out of range");

	// Every code fits in its own width
	a_code_fits: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[11:0] >> m_tdata[15:12]) == 12'd0))
		else $error("code wider than its code width");

endmodule

bind lzw_stream_encoder lzwe_checker u_lzwe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
